// ===== rtl/dwag_pkg.sv =====
`timescale 1ns / 1ps
// Package for the DMA window address generator: field widths, table geometry,
// status and register codes, and the payload struct. No dependencies.
package dwag_pkg;

    // Table geometry and counter depth
    localparam int ENTRY_COUNT   = 4096;
    localparam int CHUNK_BITS    = 22;
    localparam int CHUNK_ENTRIES = 64;
    localparam int CHUNK_AW      = (CHUNK_ENTRIES > 1) ? $clog2(CHUNK_ENTRIES) : 1;
    localparam int ENTRY_CNT_W   = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    // Field widths
    localparam int ADDR_W      = 56;
    localparam int WORD_W      = 32;
    localparam int XFER_W      = 13;
    localparam int HDR_W       = 12;
    localparam int SLOT_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_W     = 12;
    localparam int CI_OUT_W    = 8;
    localparam int PAGE_BITS   = 12;
    localparam int UNIT_ALIGN  = 6;
    localparam int UNIT_W      = 14;
    localparam int UNITS_W     = WORD_W - UNIT_ALIGN;
    localparam int CI_W        = WORD_W - CHUNK_BITS;

    // Configuration port
    localparam int REG_IDX_W = 2;
    localparam int PADDR_W   = REG_IDX_W + 2;

    localparam logic [PAGE_BITS:0] PAGE_SIZE = 13'h1000;

    // Register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_WINDOW = 2'd0,
        REG_XFER   = 2'd1,
        REG_HDR    = 2'd2,
        REG_MODE   = 2'd3
    } t_reg;

    // Request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_GEN  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_CROSS  = 2'd1,
        ST_WINDOW = 2'd2,
        ST_CHUNK  = 2'd3
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [ENTRY_W-1:0]    entry_index;
        logic [ADDR_W-1:0]     dma_address;
        logic [CI_OUT_W-1:0]   chunk_index;
        logic [WORD_W-1:0]     linear_address;
    } t_rsp;

endpackage

// ===== rtl/dwag_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying load and generate items.
// Depends on dwag_pkg.
interface dwag_req_if;
    import dwag_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [SLOT_W-1:0]   chunk_slot;
    logic [ADDR_W-1:0]   chunk_base;
    logic [WORD_W-1:0]   random_value;

    modport source (output valid, req_type, chunk_slot, chunk_base, random_value,
                    input ready);
    modport sink   (input valid, req_type, chunk_slot, chunk_base, random_value,
                    output ready);
endinterface

// ===== rtl/dwag_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one generated address beat.
// Depends on dwag_pkg.
interface dwag_rsp_if;
    import dwag_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ENTRY_W-1:0]   entry_index;
    logic [ADDR_W-1:0]    dma_address;
    logic [CI_OUT_W-1:0]  chunk_index;
    logic [WORD_W-1:0]    linear_address;

    modport source (output valid, status, entry_index, dma_address, chunk_index,
                    linear_address, input ready);
    modport sink   (input valid, status, entry_index, dma_address, chunk_index,
                    linear_address, output ready);
endinterface

// ===== rtl/dwag_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dwag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

// ===== rtl/dma_window_address_generator.sv =====
`timescale 1ns / 1ps
// DMA window address generator: a load beat is written to the chunk table at accept.
// A generate beat runs the bit-serial slot modulo, then multiply, page check, table read
// (skipped if rejected or beyond the table) and hand-off to the result register; a window
// too small goes straight to hand-off. One item in work: no new trial until hand-off.
// Synchronous active-low reset; after reset and each write to window, transfer or header
// size, ready stays low while the unit count is recomputed on the same divider.
module dma_window_address_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dwag_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    dwag_req_if.sink                      i_req,
    dwag_rsp_if.source                    o_rsp
);
    import dwag_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UNITS,
        S_MOD,
        S_MUL,
        S_CHECK,
        S_READ,
        S_EMIT
    } t_state;

    // Configuration registers
    logic [WORD_W-1:0]      r_window;
    logic [XFER_W-1:0]      r_xfer;
    logic [HDR_W-1:0]       r_hdr;
    logic                   r_random;

    // Control state
    t_state                 r_state;
    logic                   r_stale;
    logic [UNITS_W-1:0]     r_units;
    logic [ENTRY_CNT_W-1:0] r_entry;
    logic [WORD_W-1:0]      r_skip;
    logic [4:0]             r_cnt;
    logic                   r_skip_inc;
    logic                   r_out_valid;

    // Datapath
    logic [WORD_W-1:0]      r_dvd;
    logic [WORD_W-1:0]      r_rem;
    logic [WORD_W-1:0]      r_dvs;
    logic [WORD_W-1:0]      r_lin;
    t_rsp                   r_res;
    t_rsp                   r_out;

    logic                   w_cfg_wr;
    logic                   w_geom_wr;
    t_reg                   w_cfg_idx;
    logic [UNIT_W:0]        w_us_sum;
    logic [UNIT_W-1:0]      w_unit_sz;
    logic [WORD_W:0]        w_rem_sh;
    logic [WORD_W+1:0]      w_diff;
    logic                   w_qbit;
    logic [WORD_W-1:0]      n_rem;
    logic [WORD_W-1:0]      n_dvd;
    logic [PAGE_BITS:0]     w_avail;
    logic [CI_W-1:0]        w_ci;
    logic                   w_accept;
    logic                   w_load;
    logic                   w_rd_en;
    logic                   w_out_load;
    logic [ADDR_W-1:0]      w_rd_data;

    // APB decode; writes complete in the access phase
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = t_reg'(paddr[PADDR_W-1:2]);
    assign w_geom_wr = w_cfg_wr && (w_cfg_idx != REG_MODE);

    always_comb begin
        case (w_cfg_idx)
            REG_WINDOW: prdata = r_window;
            REG_XFER:   prdata = 32'(r_xfer);
            REG_HDR:    prdata = 32'(r_hdr);
            REG_MODE:   prdata = 32'(r_random);
            default:    prdata = '0;
        endcase
    end

    // Unit size: transfer + header rounded up to 64 bytes
    assign w_us_sum  = (UNIT_W+1)'(r_xfer) + (UNIT_W+1)'(r_hdr) + (UNIT_W+1)'(63);
    assign w_unit_sz = {w_us_sum[UNIT_W-1:UNIT_ALIGN], {UNIT_ALIGN{1'b0}}};

    // Restoring divider step, one quotient bit per cycle
    assign w_rem_sh = {r_rem, r_dvd[WORD_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dvs};
    assign w_qbit   = ~w_diff[WORD_W+1];
    assign n_rem    = w_qbit ? w_diff[WORD_W-1:0] : w_rem_sh[WORD_W-1:0];
    assign n_dvd    = {r_dvd[WORD_W-2:0], w_qbit};

    // Bytes left before the next 4 KiB boundary, and chunk number
    assign w_avail = PAGE_SIZE - {1'b0, r_lin[PAGE_BITS-1:0]};
    assign w_ci    = r_lin[WORD_W-1:CHUNK_BITS];

    assign i_req.ready = (r_state == S_IDLE) && !r_stale;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load      = w_accept && (i_req.req_type == REQ_LOAD)
                         && (32'(i_req.chunk_slot) < CHUNK_ENTRIES);
    assign w_rd_en     = (r_state == S_CHECK) && (w_avail >= 13'(r_xfer))
                         && (32'(w_ci) < CHUNK_ENTRIES);
    assign w_out_load  = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);

    // Chunk base table
    dwag_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (CHUNK_ENTRIES)
    ) u_chunk_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (CHUNK_AW'(i_req.chunk_slot)),
        .i_wr_data (i_req.chunk_base),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (CHUNK_AW'(w_ci)),
        .o_rd_data (w_rd_data)
    );

    // Output register
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.entry_index    = r_out.entry_index;
    assign o_rsp.dma_address    = r_out.dma_address;
    assign o_rsp.chunk_index    = r_out.chunk_index;
    assign o_rsp.linear_address = r_out.linear_address;

    // Sequencer, datapath and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stale     <= 1'b1;
            r_units     <= '0;
            r_entry     <= '0;
            r_skip      <= '0;
            r_cnt       <= '0;
            r_skip_inc  <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= 32'd4096;
            r_xfer      <= 13'd64;
            r_hdr       <= '0;
            r_random    <= 1'b0;
        end else begin
            // result beat: load on hand-off, clear once taken
            if (w_out_load) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            // geometry changes restart the unit count
            if (w_geom_wr) begin
                r_stale <= 1'b1;
            end

            if (w_geom_wr && (r_state == S_IDLE || r_state == S_UNITS)) begin
                r_state <= S_IDLE;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (r_stale) begin
                            // recompute unit count: window / unit size
                            if (w_unit_sz == '0) begin
                                r_units <= '0;
                                r_stale <= 1'b0;
                            end else begin
                                r_dvd   <= r_window;
                                r_dvs   <= 32'(w_unit_sz);
                                r_rem   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_UNITS;
                            end
                        end else if (w_accept && (i_req.req_type == REQ_GEN)) begin
                            r_skip_inc        <= 1'b0;
                            r_res.entry_index <= ENTRY_W'(r_entry);
                            if (r_units == '0) begin
                                r_res.status         <= ST_WINDOW;
                                r_res.dma_address    <= '0;
                                r_res.chunk_index    <= '0;
                                r_res.linear_address <= '0;
                                r_state              <= S_EMIT;
                            end else begin
                                r_dvd   <= r_random ? i_req.random_value
                                                    : 32'(r_entry) + r_skip;
                                r_dvs   <= 32'(r_units);
                                r_rem   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_MOD;
                            end
                        end
                    end

                    S_UNITS: begin
                        r_dvd <= n_dvd;
                        r_rem <= n_rem;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'd31) begin
                            r_units <= UNITS_W'(n_dvd);
                            r_stale <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end

                    S_MOD: begin
                        r_dvd <= n_dvd;
                        r_rem <= n_rem;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'd31) begin
                            r_state <= S_MUL;
                        end
                    end

                    // slot remainder times unit size plus header offset
                    S_MUL: begin
                        r_lin   <= 32'(r_rem[UNITS_W-1:0] * w_unit_sz) + 32'(r_hdr);
                        r_state <= S_CHECK;
                    end

                    S_CHECK: begin
                        r_res.linear_address <= r_lin;
                        r_res.dma_address    <= '0;
                        r_res.chunk_index    <= '0;
                        if (w_avail < 13'(r_xfer)) begin
                            r_res.status <= ST_CROSS;
                            r_skip_inc   <= !r_random;
                            r_state      <= S_EMIT;
                        end else if (32'(w_ci) >= CHUNK_ENTRIES) begin
                            r_res.status <= ST_CHUNK;
                            r_state      <= S_EMIT;
                        end else begin
                            r_res.status <= ST_OK;
                            r_state      <= S_READ;
                        end
                    end

                    // chunk base plus offset inside the chunk
                    S_READ: begin
                        r_res.dma_address <= w_rd_data + ADDR_W'(r_lin[CHUNK_BITS-1:0]);
                        r_res.chunk_index <= CI_OUT_W'(w_ci);
                        r_state           <= S_EMIT;
                    end

                    // hand the result to the output register, then commit counters
                    S_EMIT: begin
                        if (w_out_load) begin
                            if (r_res.status == ST_OK) begin
                                if (32'(r_entry) == ENTRY_COUNT - 1) begin
                                    r_entry <= '0;
                                end else begin
                                    r_entry <= r_entry + 1'b1;
                                end
                            end
                            if (r_skip_inc) begin
                                r_skip <= r_skip + 32'd1;
                            end
                            r_state <= S_IDLE;
                        end
                    end

                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end

            // Register writes
            if (w_cfg_wr) begin
                case (w_cfg_idx)
                    REG_WINDOW: r_window <= pwdata;
                    REG_XFER:   r_xfer   <= pwdata[XFER_W-1:0];
                    REG_HDR:    r_hdr    <= pwdata[HDR_W-1:0];
                    REG_MODE:   r_random <= pwdata[0];
                    default:    r_random <= r_random;
                endcase
            end
        end
    end
endmodule

// ===== dv/dma_window_address_generator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dma_window_address_generator: predicts every result
// beat from the accepted request beats and the APB register writes.
// Depends on dwag_pkg, dwag_req_if, dwag_rsp_if and the RTL top.
module dma_window_address_generator_test;
    import dwag_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PAUSE_CYCLES = 48;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 44;
    localparam int LAST_ITEMS   = 40;

    // Address predictor plus the queue of results still owed by the block
    class dwag_scoreboard;
        logic [WORD_W-1:0]  window_size;
        logic [XFER_W-1:0]  xfer_size;
        logic [HDR_W-1:0]   hdr_offset;
        logic               rand_mode;
        int                 entry_ctr;
        logic [WORD_W-1:0]  skip_ctr;
        logic [ADDR_W-1:0]  chunk_tbl [CHUNK_ENTRIES];
        t_rsp               pending_addrs [$];
        int                 errors;
        int                 results;
        int                 loads;
        int                 wraps;
        int                 status_seen [4];

        function new();
            window_size = 32'd4096;
            xfer_size   = 13'd64;
            hdr_offset  = '0;
            rand_mode   = 1'b0;
            entry_ctr   = 0;
            skip_ctr    = '0;
            errors      = 0;
            results     = 0;
            loads       = 0;
            wraps       = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void write_reg(t_reg idx, logic [31:0] val);
            case (idx)
                REG_WINDOW: window_size = val;
                REG_XFER:   xfer_size   = val[XFER_W-1:0];
                REG_HDR:    hdr_offset  = val[HDR_W-1:0];
                REG_MODE:   rand_mode   = val[0];
                default: ;
            endcase
        endfunction

        // Work out the result of one accepted request beat
        function void note_request(logic kind, logic [SLOT_W-1:0] slot,
                                   logic [ADDR_W-1:0] base, logic [WORD_W-1:0] rnd);
            logic [31:0] unit_sz;
            logic [31:0] units;
            logic [31:0] slot_no;
            logic [31:0] lin;
            logic [31:0] avail;
            logic [31:0] ci;
            logic [63:0] lin_wide;
            t_rsp        exp;
            if (kind == REQ_LOAD) begin
                // loads past the table are dropped
                if (slot < CHUNK_ENTRIES) chunk_tbl[slot] = base;
                loads++;
                return;
            end
            exp = '0;
            exp.entry_index = entry_ctr[ENTRY_W-1:0];
            unit_sz = (32'(xfer_size) + 32'(hdr_offset) + 32'd63) & ~32'd63;
            units = (unit_sz == 0) ? 32'd0 : window_size / unit_sz;
            if (units == 0) begin
                exp.status = ST_WINDOW;
            end else begin
                slot_no = rand_mode ? rnd : 32'(entry_ctr) + skip_ctr;
                lin_wide = 64'(slot_no % units) * 64'(unit_sz) + 64'(hdr_offset);
                lin = lin_wide[31:0];
                exp.linear_address = lin;
                avail = 32'h1000 - 32'(lin[PAGE_BITS-1:0]);
                if (avail < 32'(xfer_size)) begin
                    // page crossing: only sequential mode moves on
                    exp.status = ST_CROSS;
                    if (!rand_mode) skip_ctr = skip_ctr + 1;
                end else begin
                    ci = lin >> CHUNK_BITS;
                    if (ci >= CHUNK_ENTRIES) begin
                        exp.status = ST_CHUNK;
                    end else begin
                        exp.status = ST_OK;
                        exp.chunk_index = ci[CI_OUT_W-1:0];
                        exp.dma_address = chunk_tbl[ci] + ADDR_W'(lin[CHUNK_BITS-1:0]);
                        entry_ctr = (entry_ctr + 1) % ENTRY_COUNT;
                        if (entry_ctr == 0) wraps++;
                    end
                end
            end
            pending_addrs.push_back(exp);
        endfunction

        function void flag(string what, t_rsp exp, t_rsp got);
            errors++;
            if (errors <= 10) begin
                $display("%0t %s: exp st %0d idx %0d dma %h ci %0d lin %h",
                         $time, what, exp.status, exp.entry_index, exp.dma_address,
                         exp.chunk_index, exp.linear_address);
                $display("    got st %0d idx %0d dma %h ci %0d lin %h",
                         got.status, got.entry_index, got.dma_address,
                         got.chunk_index, got.linear_address);
            end
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_result(t_rsp got);
            t_rsp exp;
            results++;
            status_seen[got.status]++;
            if (pending_addrs.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            exp = pending_addrs.pop_front();
            if (got.status !== exp.status || got.entry_index !== exp.entry_index ||
                got.dma_address !== exp.dma_address || got.chunk_index !== exp.chunk_index ||
                got.linear_address !== exp.linear_address)
                flag("mismatch", exp, got);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    int                    cycle_count = 0;
    bit                    idle_on = 1'b0;
    bit                    stall_on = 1'b0;
    bit                    hold_req = 1'b0;
    dwag_scoreboard        sb = new();

    dwag_req_if req_if ();
    dwag_rsp_if rsp_if ();

    dma_window_address_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Watchdog
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("tb: failure");
        $finish;
    end

    // Beat monitor on both channels
    always @(posedge i_clk) begin
        t_rsp got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.req_type, req_if.chunk_slot, req_if.chunk_base,
                                req_if.random_value);
            if (rsp_if.valid && rsp_if.ready) begin
                got.status         = t_status'(rsp_if.status);
                got.entry_index    = rsp_if.entry_index;
                got.dma_address    = rsp_if.dma_address;
                got.chunk_index    = rsp_if.chunk_index;
                got.linear_address = rsp_if.linear_address;
                sb.check_result(got);
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin
        rsp_if.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                rsp_if.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                repeat (stall_on ? $urandom_range(1, 12) : 1) @(posedge i_clk);
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand_base();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ADDR_W-1:0];
    endfunction

    // Slot values lean on the extremes now and then
    function automatic logic [WORD_W-1:0] rand_slot_no();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offer one request beat, with an optional gap first; returns once accepted
    task automatic send_beat(logic kind, logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] base,
                             logic [WORD_W-1:0] rnd);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= kind;
        req_if.chunk_slot   <= slot;
        req_if.chunk_base   <= base;
        req_if.random_value <= rnd;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic send_gen(logic [WORD_W-1:0] rnd);
        send_beat(REQ_GEN, SLOT_W'($urandom()), rand_base(), rnd);
    endtask

    // Mostly trials, some loads anywhere in the slot range
    task automatic send_random();
        if ($urandom_range(0, 99) < 15)
            send_beat(REQ_LOAD, SLOT_W'($urandom_range(0, 255)), rand_base(), $urandom());
        else
            send_gen(rand_slot_no());
    endtask

    // Wait one edge so the monitor has logged the last beat, then for every result
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_addrs.size() != 0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic apb_write(t_reg idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers change only with the block idle; loads leave no result to wait on
    task automatic set_config(logic [31:0] win, logic [31:0] xfer, logic [31:0] hdr,
                              logic [31:0] mode);
        drain();
        repeat (PAUSE_CYCLES) @(posedge i_clk);
        apb_write(REG_WINDOW, win);
        repeat (PAUSE_CYCLES) @(posedge i_clk);
        apb_write(REG_XFER, xfer);
        repeat (PAUSE_CYCLES) @(posedge i_clk);
        apb_write(REG_HDR, hdr);
        repeat (PAUSE_CYCLES) @(posedge i_clk);
        apb_write(REG_MODE, mode);
    endtask

    function automatic logic [31:0] pick_window();
        case ($urandom_range(0, 6))
            0: return 32'd0;
            1: return $urandom_range(1, 8191);
            2: return 32'd4096;
            3: return $urandom_range(1, 64) * 4096;
            4: return $urandom();
            5: return 32'hFFFF_FFFF;
            default: return 32'h1000_0000 | ($urandom() & 32'h0FFF_FFFF);
        endcase
    endfunction

    function automatic logic [31:0] pick_xfer();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'd64;
            2: return $urandom_range(1, 4096);
            3: return 32'd4096;
            4: return $urandom_range(4097, 8191);
            default: return $urandom_range(1, 512);
        endcase
    endfunction

    function automatic logic [31:0] pick_hdr();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'd4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_LOAD;
        req_if.chunk_slot   = '0;
        req_if.chunk_base   = '0;
        req_if.random_value = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (PAUSE_CYCLES) @(posedge i_clk);

        // Fill the whole chunk table so no trial reads an unwritten entry
        idle_on  = 1'b1;
        stall_on = 1'b1;
        send_beat(REQ_LOAD, 8'd0, '1, $urandom());
        send_beat(REQ_LOAD, 8'd1, '0, $urandom());
        for (int s = 2; s < CHUNK_ENTRIES; s++)
            send_beat(REQ_LOAD, s[SLOT_W-1:0], rand_base(), $urandom());
        // loads past the table end
        send_beat(REQ_LOAD, 8'd64, '1, '1);
        send_beat(REQ_LOAD, 8'd255, '1, '1);

        // Directed: reset settings, both ways to a window too small
        send_gen('0);
        send_gen('1);
        set_config(32'd0, 32'd64, 32'd0, 32'd0);
        send_gen($urandom());
        set_config(32'd4096, 32'd0, 32'd0, 32'd1);
        send_gen($urandom());
        // Random mode, full window, one-page transfers: chunk 0, 63, past table
        set_config(32'hFFFF_FFFF, 32'd4096, 32'd0, 32'd1);
        send_gen(32'd0);
        send_gen(32'd1);
        send_gen(32'h0000_FFFF);
        send_gen(32'h0001_0000);
        send_gen(32'hFFFF_FFFF);
        // Header pushes every trial over the page: sequential skip count grows
        set_config(32'hFFFF_FFFF, 32'd4096, 32'd4095, 32'd0);
        send_gen($urandom());
        send_gen($urandom());
        // Oversized transfer always rejects
        set_config(32'hFFFF_FFFF, 32'd8191, 32'd0, 32'd0);
        send_gen($urandom());
        send_gen($urandom());
        // One byte right at the page end
        set_config(32'hFFFF_FFFF, 32'd1, 32'd4095, 32'd0);
        send_gen($urandom());
        send_gen($urandom());
        send_gen($urandom());
        // Sequential with a nonzero skip count
        set_config(32'hFFFF_FFFF, 32'd4096, 32'd0, 32'd0);
        send_gen($urandom());
        send_gen($urandom());

        // Random phases
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_config(pick_window(), pick_xfer(), pick_hdr(), p % 2);
            stall_on = (p % 3 != 2);
            idle_on  = (p % 4 != 3);
            if (p == 1) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender waits out every owed result once mid-phase
                if (p == 6 && n == PHASE_ITEMS / 2) drain();
                send_random();
            end
        end

        // Last part, no idling: back-to-back sequential trials
        idle_on  = 1'b0;
        stall_on = 1'b0;
        set_config(32'd4096, 32'd64, 32'd0, 32'd0);
        repeat (LAST_ITEMS) send_gen($urandom());

        drain();
        repeat (64) @(posedge i_clk);
        $display("summary: %0d loads, %0d results (ok %0d, cross %0d, window %0d, chunk %0d)",
                 sb.loads, sb.results, sb.status_seen[ST_OK], sb.status_seen[ST_CROSS],
                 sb.status_seen[ST_WINDOW], sb.status_seen[ST_CHUNK]);
        $display("summary: %0d entry counter wraps, %0d mismatches, %0d cycles",
                 sb.wraps, sb.errors, cycle_count);
        if (sb.errors == 0 && sb.pending_addrs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
